### sv/vpa_pkg.sv
`timescale 1ns / 1ps
package vpa_pkg;

	localparam int SEGMENTS    = 32;
	localparam int SEG_IDX_W   = $clog2(SEGMENTS);
	localparam int SEG_CNT_W   = $clog2(SEGMENTS + 1);
	localparam int QUEUE_DEPTH = 16;
	localparam int Q_IDX_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
	localparam int LEN_W       = 16;
	localparam int ID_W        = 8;
	localparam int TIME_W      = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 24;

	localparam logic [LEN_W-1:0]  REGION_RESET = LEN_W'(1000);
	localparam logic [TIME_W-1:0] NEVER        = '1;

	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic REG_FIT_POLICY  = 1'b0;
	localparam logic REG_REGION_SIZE = 1'b1;

	typedef enum logic [1:0] {
		OC_ALLOC      = 2'd0,
		OC_QUEUED     = 2'd1,
		OC_DROP_QUEUE = 2'd2,
		OC_DROP_TABLE = 2'd3
	} outcome_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [TIME_W-1:0] a;
		logic [TIME_W-1:0] b;
		logic [TIME_W-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] res;
		logic              lt;
		logic              eq;
		logic              lt_c;
		logic              gt_c;
	} alu_rsp_t;

	typedef struct packed {
		outcome_t         outcome;
		logic [ID_W-1:0]  owner_id;
		logic [LEN_W-1:0] base;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] size;
		logic [LEN_W-1:0] hold;
	} wq_entry_t;

endpackage

### sv/vpa_alu.sv
`timescale 1ns / 1ps
module vpa_alu (
	input  vpa_pkg::alu_req_t req,
	output vpa_pkg::alu_rsp_t rsp
);
	import vpa_pkg::*;

	always_comb begin
		unique case (req.op)
			ALU_ADD: rsp.res = req.a + req.b;
			ALU_SUB: rsp.res = req.a - req.b;
			default: rsp.res = req.a;
		endcase
		rsp.lt   = req.a < req.b;
		rsp.eq   = req.a == req.b;
		rsp.lt_c = req.a < req.c;
		rsp.gt_c = req.a > req.c;
	end

endmodule

### sv/vpa_out_reg.sv
`timescale 1ns / 1ps
module vpa_out_reg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  vpa_pkg::result_t                din,
	output logic                            can_push,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	output logic [1:0]                      m_axis_tuser,
	output logic                            m_axis_tlast
);
	import vpa_pkg::*;

	logic    valid_q;
	result_t data_q;

	assign can_push = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push && can_push) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push && can_push) begin
			data_q <= din;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {data_q.base, data_q.owner_id};
	assign m_axis_tuser  = data_q.outcome;
	assign m_axis_tlast  = data_q.last;

endmodule

### sv/variable_partition_allocator_unit.sv
`timescale 1ns / 1ps
// Channel  | Signals                         | Beat contents (low bit first)
// s_axis   | tvalid tready tdata[39:0] tuser | tdata: request_id, request_size, hold_time;
//          |                                 | tuser: op
// m_axis   | tvalid tready tdata[23:0] tuser | tdata: owner_id, base_address;
//          | tlast                           | tuser: outcome; tlast: last
// cfg      | cfg_we cfg_index cfg_data[15:0] | 0 fit_policy, 1 region_size
//
// One item at a time; s_axis_tready is high only while idle.
// Arrival: one table entry compared per cycle by the shared ALU.
// Tick: expiry and merge walks over the table, plus per retried request
// a table scan (best/worst fit) or a hole walk over the queue (first fit).
// Results of a tick are held one deep so the final beat carries tlast; a stalled
// m_axis holds the sequencer. Reset gives one free segment of 1000 units.
module variable_partition_allocator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [vpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // request_id, request_size, hold_time
	input  logic                            s_axis_tuser,  // op
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [vpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // owner_id, base_address
	output logic [1:0]                      m_axis_tuser,  // outcome
	output logic                            m_axis_tlast,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [vpa_pkg::LEN_W-1:0]       cfg_data
);
	import vpa_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b00000000001,
		S_CHOOSE   = 11'b00000000010,
		S_TAKE     = 11'b00000000100,
		S_SPLIT    = 11'b00000001000,
		S_OWN      = 11'b00000010000,
		S_EMIT     = 11'b00000100000,
		S_FREE     = 11'b00001000000,
		S_MERGE    = 11'b00010000000,
		S_RETRY_BW = 11'b00100000000,
		S_RETRY_FF = 11'b01000000000,
		S_FLUSH    = 11'b10000000000
	} state_t;

	typedef enum logic [1:0] {
		CTX_ARRIVAL = 2'd0,
		CTX_BW      = 2'd1,
		CTX_FF      = 2'd2
	} ctx_t;

	state_t state_q;
	ctx_t   ctx_q;

	logic [LEN_W-1:0]  seg_base_q [SEGMENTS];
	logic [LEN_W-1:0]  seg_len_q  [SEGMENTS];
	logic              seg_free_q [SEGMENTS];
	logic [ID_W-1:0]   seg_owner_q[SEGMENTS];
	logic [TIME_W-1:0] seg_exp_q  [SEGMENTS];
	wq_entry_t         wq_q       [QUEUE_DEPTH];

	logic [SEG_CNT_W-1:0] cnt_q, p_q;
	logic [SEG_IDX_W-1:0] pick_q;
	logic                 pick_v_q;
	logic [LEN_W-1:0]     pick_len_q, prev_len_q, rem_q;
	logic                 prev_free_q, freed_q;
	logic [Q_CNT_W-1:0]   wcnt_q, j_q;
	logic [RES_CNT_W-1:0] nres_q;
	logic [TIME_W-1:0]    time_q;
	logic [1:0]           policy_q;
	logic [ID_W-1:0]      req_id_q;
	logic [LEN_W-1:0]     req_size_q, req_hold_q;
	result_t              res_q, pend_q;
	logic                 pend_v_q;

	logic [SEG_IDX_W-1:0] p_idx;
	logic [SEG_CNT_W-1:0] pm1_c, pp1_c;
	logic [LEN_W-1:0]     rd_base, rd_len;
	logic                 rd_free;
	logic [TIME_W-1:0]    rd_exp;
	wq_entry_t            q_rd;
	logic                 bw, fit, p_end, take_full, q_push, q_remove, res_max;
	logic                 push, can_push;
	result_t              push_data;
	alu_req_t             alu_req;
	alu_rsp_t             alu_rsp;
	logic [LEN_W-1:0]     in_size, in_hold;

	assign p_idx   = p_q[SEG_IDX_W-1:0];
	assign pm1_c   = p_q - 1'b1;
	assign pp1_c   = p_q + 1'b1;
	assign rd_base = seg_base_q[p_idx];
	assign rd_len  = seg_len_q[p_idx];
	assign rd_free = seg_free_q[p_idx];
	assign rd_exp  = seg_exp_q[p_idx];
	assign q_rd    = wq_q[j_q[Q_IDX_W-1:0]];
	assign bw      = (policy_q == POL_BEST) || (policy_q == POL_WORST);
	assign fit     = rd_free && !alu_rsp.lt;
	assign p_end   = p_q >= cnt_q;
	assign res_max = nres_q == RES_CNT_W'(MAX_RESULTS);
	assign in_size = (s_axis_tdata[23:8] == '0) ? LEN_W'(1) : s_axis_tdata[23:8];
	assign in_hold = (s_axis_tdata[39:24] == '0) ? LEN_W'(1) : s_axis_tdata[39:24];

	assign take_full = (state_q == S_TAKE) && !alu_rsp.eq
		&& (cnt_q == SEG_CNT_W'(SEGMENTS));
	assign q_remove  = (take_full || state_q == S_OWN) && (ctx_q != CTX_ARRIVAL);
	assign q_push    = (state_q == S_CHOOSE) && p_end && !pick_v_q
		&& (ctx_q == CTX_ARRIVAL) && (wcnt_q < Q_CNT_W'(QUEUE_DEPTH));

	assign s_axis_tready = state_q == S_IDLE;

	vpa_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	// route operands of the shared unit per sequencer step
	always_comb begin
		alu_req = '{op: ALU_ADD, a: '0, b: '0, c: '0};
		unique case (state_q)
			S_IDLE: begin
				alu_req.a = time_q;
				alu_req.b = TIME_W'(1);
			end
			S_CHOOSE: begin
				alu_req.a = TIME_W'(rd_len);
				alu_req.b = TIME_W'(req_size_q);
				alu_req.c = TIME_W'(pick_len_q);
			end
			S_TAKE: begin
				alu_req.op = ALU_SUB;
				alu_req.a  = TIME_W'(rd_len);
				alu_req.b  = TIME_W'(req_size_q);
			end
			S_SPLIT: begin
				alu_req.a = TIME_W'(rd_base);
				alu_req.b = TIME_W'(req_size_q);
			end
			S_OWN: begin
				alu_req.a = time_q;
				alu_req.b = TIME_W'(req_hold_q);
			end
			S_FREE: begin
				alu_req.a = rd_exp;
				alu_req.b = time_q;
			end
			S_MERGE: begin
				alu_req.a = TIME_W'(prev_len_q);
				alu_req.b = TIME_W'(rd_len);
			end
			S_RETRY_FF: begin
				alu_req.a = TIME_W'(rd_len);
				alu_req.b = TIME_W'(q_rd.size);
			end
			default: ;
		endcase
	end

	always_comb begin
		push      = 1'b0;
		push_data = pend_q;
		if (state_q == S_EMIT) begin
			if (ctx_q == CTX_ARRIVAL) begin
				push      = 1'b1;
				push_data = res_q;
				push_data.last = 1'b1;
			end else begin
				push = pend_v_q;
				push_data.last = 1'b0;
			end
		end else if (state_q == S_FLUSH) begin
			push = pend_v_q;
			push_data.last = 1'b1;
		end
	end

	vpa_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.din          (push_data),
		.can_push     (can_push),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	always_ff @(posedge clk) begin
		if (q_push) begin
			wq_q[wcnt_q[Q_IDX_W-1:0]] <= '{id: req_id_q, size: req_size_q, hold: req_hold_q};
		end
		if (q_remove) begin
			for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
				if (Q_CNT_W'(k) >= j_q) begin
					wq_q[k] <= wq_q[k+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ctx_q       <= CTX_ARRIVAL;
			for (int k = 0; k < SEGMENTS; k++) begin
				seg_base_q[k]  <= '0;
				seg_len_q[k]   <= '0;
				seg_free_q[k]  <= 1'b1;
				seg_owner_q[k] <= '0;
				seg_exp_q[k]   <= NEVER;
			end
			seg_len_q[0] <= REGION_RESET;
			cnt_q       <= SEG_CNT_W'(1);
			p_q         <= '0;
			pick_q      <= '0;
			pick_v_q    <= 1'b0;
			pick_len_q  <= '0;
			prev_len_q  <= '0;
			prev_free_q <= 1'b0;
			rem_q       <= '0;
			freed_q     <= 1'b0;
			wcnt_q      <= '0;
			j_q         <= '0;
			nres_q      <= '0;
			time_q      <= '0;
			policy_q    <= POL_FIRST;
			req_id_q    <= '0;
			req_size_q  <= '0;
			req_hold_q  <= '0;
			res_q       <= '0;
			pend_q      <= '0;
			pend_v_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_FIT_POLICY: policy_q <= cfg_data[1:0];
					REG_REGION_SIZE: begin
						seg_base_q[0] <= '0;
						seg_len_q[0]  <= cfg_data;
						seg_free_q[0] <= 1'b1;
						cnt_q         <= SEG_CNT_W'(1);
						wcnt_q        <= '0;
					end
					default: ;
				endcase
			end
			if (q_push) begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			if (q_remove) begin
				wcnt_q <= wcnt_q - 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						req_id_q   <= s_axis_tdata[7:0];
						req_size_q <= in_size;
						req_hold_q <= in_hold;
						p_q        <= '0;
						pick_v_q   <= 1'b0;
						if (s_axis_tuser) begin
							ctx_q   <= CTX_ARRIVAL;
							state_q <= S_CHOOSE;
						end else begin
							time_q  <= alu_rsp.res;
							freed_q <= 1'b0;
							state_q <= S_FREE;
						end
					end
				end
				S_CHOOSE: begin
					if (p_end) begin
						if (pick_v_q) begin
							p_q     <= SEG_CNT_W'(pick_q);
							state_q <= S_TAKE;
						end else if (ctx_q == CTX_ARRIVAL) begin
							res_q.outcome  <= (wcnt_q < Q_CNT_W'(QUEUE_DEPTH)) ?
								OC_QUEUED : OC_DROP_QUEUE;
							res_q.owner_id <= req_id_q;
							res_q.base     <= '0;
							state_q        <= S_EMIT;
						end else begin
							j_q     <= j_q + 1'b1;
							state_q <= S_RETRY_BW;
						end
					end else if (fit && !bw) begin
						state_q <= S_TAKE;
					end else begin
						if (fit && (!pick_v_q
							|| (policy_q == POL_BEST && alu_rsp.lt_c)
							|| (policy_q == POL_WORST && alu_rsp.gt_c))) begin
							pick_q     <= p_idx;
							pick_v_q   <= 1'b1;
							pick_len_q <= rd_len;
						end
						p_q <= p_q + 1'b1;
					end
				end
				S_TAKE: begin
					res_q.owner_id <= req_id_q;
					if (alu_rsp.eq) begin
						state_q <= S_OWN;
					end else if (take_full) begin
						res_q.outcome <= OC_DROP_TABLE;
						res_q.base    <= '0;
						state_q       <= S_EMIT;
					end else begin
						rem_q   <= alu_rsp.res[LEN_W-1:0];
						state_q <= S_SPLIT;
					end
				end
				S_SPLIT: begin
					// open a slot above the hole for the remainder
					for (int k = 1; k < SEGMENTS; k++) begin
						if (SEG_CNT_W'(k) > pp1_c) begin
							seg_base_q[k]  <= seg_base_q[k-1];
							seg_len_q[k]   <= seg_len_q[k-1];
							seg_free_q[k]  <= seg_free_q[k-1];
							seg_owner_q[k] <= seg_owner_q[k-1];
							seg_exp_q[k]   <= seg_exp_q[k-1];
						end
					end
					seg_base_q[pp1_c[SEG_IDX_W-1:0]] <= alu_rsp.res[LEN_W-1:0];
					seg_len_q[pp1_c[SEG_IDX_W-1:0]]  <= rem_q;
					seg_free_q[pp1_c[SEG_IDX_W-1:0]] <= 1'b1;
					seg_exp_q[pp1_c[SEG_IDX_W-1:0]]  <= NEVER;
					seg_len_q[p_idx] <= req_size_q;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_OWN;
				end
				S_OWN: begin
					seg_exp_q[p_idx]   <= alu_rsp.res;
					seg_free_q[p_idx]  <= 1'b0;
					seg_owner_q[p_idx] <= req_id_q;
					res_q.outcome      <= OC_ALLOC;
					res_q.owner_id     <= req_id_q;
					res_q.base         <= rd_base;
					state_q            <= S_EMIT;
				end
				S_EMIT: begin
					if (ctx_q == CTX_ARRIVAL) begin
						if (can_push) begin
							state_q <= S_IDLE;
						end
					end else if (!pend_v_q || can_push) begin
						pend_q   <= res_q;
						pend_v_q <= 1'b1;
						nres_q   <= nres_q + 1'b1;
						state_q  <= (ctx_q == CTX_BW) ? S_RETRY_BW : S_RETRY_FF;
					end
				end
				S_FREE: begin
					if (p_end) begin
						p_q         <= SEG_CNT_W'(1);
						prev_free_q <= seg_free_q[0];
						prev_len_q  <= seg_len_q[0];
						state_q     <= S_MERGE;
					end else begin
						if (!rd_free && alu_rsp.eq) begin
							seg_free_q[p_idx] <= 1'b1;
							seg_exp_q[p_idx]  <= NEVER;
							freed_q           <= 1'b1;
						end
						p_q <= p_q + 1'b1;
					end
				end
				S_MERGE: begin
					if (p_end) begin
						nres_q <= '0;
						j_q    <= '0;
						p_q    <= '0;
						if (freed_q && wcnt_q != '0) begin
							ctx_q   <= bw ? CTX_BW : CTX_FF;
							state_q <= bw ? S_RETRY_BW : S_RETRY_FF;
						end else begin
							state_q <= S_IDLE;
						end
					end else if (prev_free_q && rd_free) begin
						// fold this hole into the one below and close the gap
						for (int k = 0; k < SEGMENTS - 1; k++) begin
							if (SEG_CNT_W'(k) >= p_q) begin
								seg_base_q[k]  <= seg_base_q[k+1];
								seg_len_q[k]   <= seg_len_q[k+1];
								seg_free_q[k]  <= seg_free_q[k+1];
								seg_owner_q[k] <= seg_owner_q[k+1];
								seg_exp_q[k]   <= seg_exp_q[k+1];
							end
						end
						seg_len_q[pm1_c[SEG_IDX_W-1:0]] <= alu_rsp.res[LEN_W-1:0];
						prev_len_q <= alu_rsp.res[LEN_W-1:0];
						cnt_q      <= cnt_q - 1'b1;
					end else begin
						prev_free_q <= rd_free;
						prev_len_q  <= rd_len;
						p_q         <= p_q + 1'b1;
					end
				end
				S_RETRY_BW: begin
					if (j_q >= wcnt_q || res_max) begin
						state_q <= S_FLUSH;
					end else begin
						req_id_q   <= q_rd.id;
						req_size_q <= q_rd.size;
						req_hold_q <= q_rd.hold;
						p_q        <= '0;
						pick_v_q   <= 1'b0;
						state_q    <= S_CHOOSE;
					end
				end
				S_RETRY_FF: begin
					if (p_end || res_max) begin
						state_q <= S_FLUSH;
					end else if (!rd_free || j_q >= wcnt_q) begin
						p_q <= p_q + 1'b1;
						j_q <= '0;
					end else if (alu_rsp.lt) begin
						j_q <= j_q + 1'b1;
					end else begin
						req_id_q   <= q_rd.id;
						req_size_q <= q_rd.size;
						req_hold_q <= q_rd.hold;
						state_q    <= S_TAKE;
					end
				end
				S_FLUSH: begin
					if (!pend_v_q || can_push) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### sv/vpa_port_checker.sv
`timescale 1ns / 1ps
module vpa_port_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [vpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [1:0]                      m_axis_tuser,
	input logic                            m_axis_tlast
);
	import vpa_pkg::*;

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
			&& $stable(m_axis_tlast))
		else $error("result beat changed while stalled");

	// the sequencer is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input accepted back to back");

	a_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != OC_ALLOC |-> m_axis_tdata[23:8] == '0)
		else $error("base nonzero on a non-allocation result");

	// queued and queue-full drops only come from arrivals, which give one beat
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == OC_QUEUED || m_axis_tuser == OC_DROP_QUEUE)
			|-> m_axis_tlast)
		else $error("arrival result without tlast");

endmodule

bind variable_partition_allocator_unit vpa_port_checker u_vpa_port_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tuser (m_axis_tuser),
	.m_axis_tlast (m_axis_tlast)
);
